// ===== rtl/bid_pkg.sv =====
// Shared types and constants of the bounded integer deque.
package bid_pkg;

    localparam int DATA_W = 32;
    localparam int TOTAL_W = 5;

    localparam logic [2:0] OP_ADD_BACK   = 3'd0;
    localparam logic [2:0] OP_ADD_FRONT  = 3'd1;
    localparam logic [2:0] OP_TAKE_BACK  = 3'd2;
    localparam logic [2:0] OP_TAKE_FRONT = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_QUERY      = 3'd5;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ADD_BACK,
        CELL_ADD_FRONT,
        CELL_TAKE_BACK,
        CELL_TAKE_FRONT,
        CELL_CLEAR
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                  cmd;
        logic signed [DATA_W-1:0]   value;
    } cell_ctrl_t;

    // What one cell shows its neighbors: occupancy and stored value
    typedef struct packed {
        logic                       occ;
        logic signed [DATA_W-1:0]   data;
    } cell_link_t;

endpackage

// ===== rtl/bounded_integer_deque.sv =====
// Top level of the bounded integer deque: cell chain, control and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | opcode, push_value
//  out     | output    | out_valid / out_ready| front_value, back_value, element_total,
//          |           |                      | is_empty, status
//
// The accepting edge updates the cell chain and enters ST_EVAL, which loads the result
// register from cell 0 and from the OR tree that picks the last occupied cell.
// A new transaction is taken in ST_IDLE once the result slot is empty or is being drained.
// rst_n clears all occupancy bits, the element counter and the handshake state at once;
// cell values are left as they are and are only ever read while occupied.
// An output stall holds the result and blocks input until the result is taken.
module bounded_integer_deque
    import bid_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  opcode,
    input  logic signed [DATA_W-1:0]    push_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [DATA_W-1:0]    front_value,
    output logic signed [DATA_W-1:0]    back_value,
    output logic [TOTAL_W-1:0]          element_total,
    output logic                        is_empty,
    output logic [1:0]                  status
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t                     state_reg;
    logic                       out_valid_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;
    logic signed [DATA_W-1:0]   front_reg;
    logic signed [DATA_W-1:0]   back_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic                       empty_reg;

    logic                       accept;
    logic                       full;
    logic                       empty;
    cell_ctrl_t                 ctrl;
    cell_cmd_t                  cmd;
    cell_link_t                 link [DEPTH];
    cell_link_t                 left_in [DEPTH];
    cell_link_t                 right_in [DEPTH];
    logic signed [DATA_W-1:0]   back_tap [DEPTH];
    logic signed [DATA_W-1:0]   back_sel;
    logic [CW+TOTAL_W-1:0]      count_wide;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // occupancy is a thermometer: full when the last cell holds, empty when the first is free
    assign full  = link[DEPTH-1].occ;
    assign empty = !link[0].occ;

    // decode the operation; drop pushes to a full queue and pops from an empty one
    always_comb
    begin
        cmd         = CELL_HOLD;
        status_next = STATUS_DONE;
        count_next  = count_reg;
        unique case (opcode) inside
            OP_ADD_BACK, OP_ADD_FRONT:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    cmd        = (opcode == OP_ADD_BACK) ? CELL_ADD_BACK : CELL_ADD_FRONT;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_TAKE_BACK, OP_TAKE_FRONT:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    cmd        = (opcode == OP_TAKE_BACK) ? CELL_TAKE_BACK : CELL_TAKE_FRONT;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_CLEAR:
            begin
                cmd        = CELL_CLEAR;
                count_next = '0;
            end
            default:
            begin
                // query and the unused codes change nothing
                cmd = CELL_HOLD;
            end
        endcase
    end

    assign ctrl.cmd   = accept ? cmd : CELL_HOLD;
    assign ctrl.value = push_value;

    // chain ends: the front takes the pushed value as an occupied neighbor,
    // the back sees a free neighbor
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_in[gi] = '{occ: 1'b1, data: push_value};
            end
            else
            begin : g_mid_left
                assign left_in[gi] = link[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in[gi] = '{occ: 1'b0, data: link[gi].data};
            end
            else
            begin : g_mid_right
                assign right_in[gi] = link[gi+1];
            end

            bid_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .left     (left_in[gi]),
                .right    (right_in[gi]),
                .own      (link[gi]),
                .back_tap (back_tap[gi])
            );
        end
    endgenerate

    // only the last occupied cell drives its tap, so an OR picks the back value
    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_sel = back_sel | back_tap[i];
        end
    end

    assign count_wide = {{TOTAL_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= STATUS_DONE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        count_reg  <= count_next;
                        status_reg <= status_next;
                        state_reg  <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload: load from the updated chain
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            front_reg <= empty ? INT_MAX : link[0].data;
            back_reg  <= empty ? INT_MAX : back_sel;
            empty_reg <= empty;
            total_reg <= count_wide[TOTAL_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign front_value   = front_reg;
    assign back_value    = back_reg;
    assign element_total = total_reg;
    assign is_empty      = empty_reg;
    assign status        = status_reg;

    // after an accepted transaction out_valid stays low in ST_EVAL, then rises with its result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid ##1 out_valid))
        else $error("result not presented two cycles after accept");

    // occupancy of the first cell and the element counter agree
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        link[0].occ == (count_reg != '0))
        else $error("cell occupancy disagrees with element counter");

    // empty flag of a shown result matches the counter
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with element counter");

    // a dropped push is reported only when the queue is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && (status == STATUS_FULL)) |-> (count_reg == CW'(DEPTH)))
        else $error("push dropped while queue not full");

endmodule

// ===== rtl/bid_cell.sv =====
// One storage cell of the deque chain: an occupancy bit and one value.
module bid_cell
    import bid_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctrl_t                  ctrl,
    input  cell_link_t                  left,
    input  cell_link_t                  right,
    output cell_link_t                  own,
    output logic signed [DATA_W-1:0]    back_tap
);

    logic                       occ_reg;
    logic                       occ_next;
    logic signed [DATA_W-1:0]   data_reg;
    logic signed [DATA_W-1:0]   data_next;
    logic                       is_last;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_ADD_BACK:
            begin
                occ_next = left.occ;
                // first free cell takes the new value
                if (left.occ && !occ_reg)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_ADD_FRONT:
            begin
                occ_next  = left.occ;
                data_next = left.data;
            end
            CELL_TAKE_BACK:
            begin
                occ_next = right.occ;
            end
            CELL_TAKE_FRONT:
            begin
                occ_next  = right.occ;
                data_next = right.data;
            end
            CELL_CLEAR:
            begin
                occ_next = 1'b0;
            end
            default:
            begin
                occ_next  = occ_reg;
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign is_last  = occ_reg && !right.occ;
    assign own.occ  = occ_reg;
    assign own.data = data_reg;
    assign back_tap = is_last ? data_reg : '0;

endmodule

// ===== test/bounded_integer_deque_tb.sv =====
// Testbench for the bounded integer deque: directed corners, biased random operations, checking.
module bounded_integer_deque_tb
    import bid_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int QUIET_LIMIT = 1000;  // cycles without any transaction before giving up
    localparam int SETTLE_CYCLES = 8;   // result slot plus chain update, with margin

    // Opcodes outside the package list; the block treats them as a query
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // One result transaction as the checker expects it
    typedef struct packed {
        logic signed [DATA_W-1:0]   front;
        logic signed [DATA_W-1:0]   back;
        logic [TOTAL_W-1:0]         total;
        logic                       empty;
        logic [1:0]                 stat;
    } deque_view_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [2:0]                 opcode;
    logic signed [DATA_W-1:0]   push_value;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [DATA_W-1:0]   front_value;
    logic signed [DATA_W-1:0]   back_value;
    logic [TOTAL_W-1:0]         element_total;
    logic                       is_empty;
    logic [1:0]                 status;

    // Shadow deque: ring store, front position and occupancy
    logic signed [DATA_W-1:0]   ring_mem [QUEUE_DEPTH];
    int                         ring_head;
    int                         ring_count;
    bit                         fill_phase;

    deque_view_t                expected_views [$];
    int                         mismatch_count;
    int                         send_idle_pct;
    int                         recv_stall_pct;

    bounded_integer_deque #(
        .DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .push_value(push_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .front_value(front_value),
        .back_value(back_value),
        .element_total(element_total),
        .is_empty(is_empty),
        .status(status)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Apply one operation to the shadow deque and return the result it must produce.
    function automatic deque_view_t apply_deque_op(input logic [2:0] op,
                                                   input logic signed [DATA_W-1:0] val);
        deque_view_t view;
        view.stat = STATUS_DONE;
        case (op)
            OP_ADD_BACK:
                if (ring_count >= QUEUE_DEPTH)
                    view.stat = STATUS_FULL;
                else
                begin
                    ring_mem[(ring_head + ring_count) % QUEUE_DEPTH] = val;
                    ring_count++;
                end
            OP_ADD_FRONT:
                if (ring_count >= QUEUE_DEPTH)
                    view.stat = STATUS_FULL;
                else
                begin
                    ring_head = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    ring_mem[ring_head] = val;
                    ring_count++;
                end
            OP_TAKE_BACK:
                if (ring_count == 0)
                    view.stat = STATUS_EMPTY;
                else
                    ring_count--;
            OP_TAKE_FRONT:
                if (ring_count == 0)
                    view.stat = STATUS_EMPTY;
                else
                begin
                    ring_head = (ring_head + 1) % QUEUE_DEPTH;
                    ring_count--;
                end
            OP_CLEAR:
            begin
                ring_head = 0;
                ring_count = 0;
            end
            default:
                ;
        endcase
        if (ring_count == 0)
        begin
            view.front = INT_MAX;
            view.back = INT_MAX;
            view.empty = 1'b1;
        end
        else
        begin
            view.front = ring_mem[ring_head];
            view.back = ring_mem[(ring_head + ring_count - 1) % QUEUE_DEPTH];
            view.empty = 1'b0;
        end
        view.total = TOTAL_W'(ring_count);
        return view;
    endfunction

    // Mostly random words, with the signed extremes, zero and minus one mixed in.
    function automatic logic signed [DATA_W-1:0] next_push_value();
        if ($urandom_range(7) != 0)
            return $urandom;
        case ($urandom_range(3))
            0: return INT_MAX;
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Pick an operation that walks the deque between empty and full: lean toward
    // pushes while filling and toward pops while draining, flip at either end.
    function automatic logic [2:0] next_deque_op();
        int roll;
        roll = $urandom_range(99);
        if (ring_count >= QUEUE_DEPTH)
            fill_phase = 1'b0;
        else if (ring_count == 0)
            fill_phase = 1'b1;
        else if ($urandom_range(99) == 0)
            fill_phase = !fill_phase;
        if (roll < 2)
            return OP_CLEAR;
        if (roll < 8)
        begin
            case ($urandom_range(2))
                0: return OP_QUERY;
                1: return OP_SPARE_6;
                default: return OP_SPARE_7;
            endcase
        end
        if ((roll < 72) == fill_phase)
            return $urandom_range(1) ? OP_ADD_BACK : OP_ADD_FRONT;
        return $urandom_range(1) ? OP_TAKE_BACK : OP_TAKE_FRONT;
    endfunction

    // Send one transaction. Call at a falling edge; returns at the falling edge
    // after acceptance with valid still high, so back-to-back items never toggle it.
    task automatic send_op(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        push_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold until every predicted result has been taken.
    task automatic wait_results_drained();
        while (expected_views.size() != 0)
            @(negedge clk);
    endtask

    // Corners: empty pops, spare opcodes, signed extremes, wrap of the front
    // position below zero, fill to capacity, pushes dropped when full, clear.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_op(OP_QUERY, '0);
        send_op(OP_TAKE_BACK, '1);
        send_op(OP_TAKE_FRONT, '1);
        send_op(OP_SPARE_6, INT_MAX);
        send_op(OP_SPARE_7, '0);
        send_op(OP_ADD_BACK, {1'b1, {(DATA_W-1){1'b0}}});
        send_op(OP_ADD_FRONT, INT_MAX);
        for (int i = 2; i < QUEUE_DEPTH; i++)
            send_op((i % 2 != 0) ? OP_ADD_BACK : OP_ADD_FRONT, next_push_value());
        send_op(OP_ADD_BACK, '1);
        send_op(OP_ADD_FRONT, '0);
        send_op(OP_TAKE_BACK, '0);
        send_op(OP_TAKE_FRONT, '0);
        send_op(OP_CLEAR, '1);
    endtask

    // Random walk under one idling profile.
    task automatic test_random_walk(input int item_count, input int idle_pct,
                                    input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (item_count)
            send_op(next_deque_op(), next_push_value());
    endtask

    // Short bursts, each followed by a pause until the block has nothing in flight.
    task automatic test_drain_pause();
        int burst;
        send_idle_pct = 33;
        recv_stall_pct = 33;
        repeat (6)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
                send_op(next_deque_op(), next_push_value());
            in_valid <= 1'b0;
            wait_results_drained();
        end
    endtask

    // Receiver: decide ready for the coming edge at each falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Checker: compare each result transaction with the oldest prediction, then
    // predict for an input transaction taken at the same edge. A result can
    // never belong to an item taken at the same edge, so this order is safe.
    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    if (front_value !== want.front)
                    begin
                        $error("front_value: expected %0d, got %0d", want.front, front_value);
                        mismatch_count++;
                    end
                    if (back_value !== want.back)
                    begin
                        $error("back_value: expected %0d, got %0d", want.back, back_value);
                        mismatch_count++;
                    end
                    if (element_total !== want.total)
                    begin
                        $error("element_total: expected %0d, got %0d",
                               want.total, element_total);
                        mismatch_count++;
                    end
                    if (is_empty !== want.empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.empty, is_empty);
                        mismatch_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, got %0d", want.stat, status);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_views = {expected_views, apply_deque_op(opcode, push_value)};
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("bounded_integer_deque_tb failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_QUERY;
        push_value = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        ring_head = 0;
        ring_count = 0;
        fill_phase = 1'b1;
        foreach (ring_mem[i])
            ring_mem[i] = '0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_walk(300, 0, 0);
        test_random_walk(300, 51, 0);
        test_random_walk(300, 0, 51);
        test_random_walk(300, 33, 33);
        test_drain_pause();

        // Drop valid, let the last results out, then give stray results time to show.
        in_valid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_views.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_views.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("bounded_integer_deque_tb passed");
        else
            $display("bounded_integer_deque_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bid_pkg.sv
rtl/bid_cell.sv
rtl/bounded_integer_deque.sv
test/bounded_integer_deque_tb.sv
